// ===== rtl/osc_message_header_deframer_top_assert.svh =====
// assertion macros for the osc message header deframer
// used by osc_message_header_deframer_top; needs clk and rst_n in scope
`ifndef OSC_MESSAGE_HEADER_DEFRAMER_TOP_ASSERT_SVH
`define OSC_MESSAGE_HEADER_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define OHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/osc_hdr_pkg.sv =====
// shared constants and helpers for the osc message header deframer
// no dependencies
`timescale 1ns / 1ps

package osc_hdr_pkg;

  localparam int CntW = 15;

  // section codes, also used as the phase of the header walk
  localparam logic [2:0] SEC_ADDR     = 3'd0;
  localparam logic [2:0] SEC_ADDR_PAD = 3'd1;
  localparam logic [2:0] SEC_TYPE     = 3'd2;
  localparam logic [2:0] SEC_TYPE_PAD = 3'd3;
  localparam logic [2:0] SEC_DATA     = 3'd4;
  localparam logic [2:0] SEC_REJECT   = 3'd5;

  localparam logic [CntW-1:0] CNT_MAX = 15'h7FFF;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;

  typedef logic [CntW-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + 15'd1;
  endfunction

endpackage

// ===== rtl/osc_message_header_deframer_top.sv =====
// Takes one message byte per beat and returns one tagged beat per byte, in order.
// A new byte can be taken every cycle unless in_stall is raised; each byte passes
// through the input register and then the result register. The header walk (phase,
// counters, padding) is worked out combinationally and updates once per byte, which
// sets the one-byte-per-cycle rate. A waiting result does not block the input register,
// so one more byte is taken while the output is stalled.
// depends on osc_hdr_pkg and osc_message_header_deframer_top_assert.svh
`timescale 1ns / 1ps

`include "osc_message_header_deframer_top_assert.svh"

module osc_message_header_deframer_top
  import osc_hdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_message_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic [2:0] out_section,
  output logic       out_message_done,
  output logic       out_message_valid,
  output cnt_t       out_address_length,
  output cnt_t       out_type_length,
  output cnt_t       out_data_offset,
  output cnt_t       out_data_length
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // header walk state
  logic [2:0] phase_r, phase_nxt;
  cnt_t       pos_r, pos_nxt;
  cnt_t       addr_cnt_r, addr_cnt_nxt;
  cnt_t       type_cnt_r, type_cnt_nxt;
  logic [2:0] pad_left_r, pad_left_nxt;
  logic       hdr_good_r, hdr_good_nxt;
  logic       type_closed_r, type_closed_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] byte_out_r;
  logic [2:0] section_r;
  logic       done_r;
  logic       msg_valid_r;
  cnt_t       addr_len_r, type_len_r, data_off_r, data_len_r;

  logic        advance;
  logic        step;
  logic [2:0]  sec;
  logic [15:0] type_start;
  logic [16:0] doff;
  logic        valid_c;
  cnt_t        doff_sat;
  cnt_t        dlen;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = advance && in_valid_r;
  assign in_stall = in_valid_r && !advance;

  always_comb begin
    phase_nxt       = phase_r;
    addr_cnt_nxt    = addr_cnt_r;
    type_cnt_nxt    = type_cnt_r;
    pad_left_nxt    = pad_left_r;
    type_closed_nxt = type_closed_r;
    hdr_good_nxt    = hdr_good_r && (pos_r != CNT_MAX);
    pos_nxt         = sat_inc(pos_r);
    sec             = SEC_REJECT;
    case (phase_r)
      SEC_ADDR: begin
        if ((pos_r == '0) && (in_byte_r != SLASH_CHAR)) begin
          sec          = SEC_REJECT;
          phase_nxt    = SEC_REJECT;
          hdr_good_nxt = 1'b0;
        end else if (in_byte_r != 8'd0) begin
          sec          = SEC_ADDR;
          addr_cnt_nxt = sat_inc(addr_cnt_r);
        end else begin
          sec          = SEC_ADDR_PAD;
          // 3 - (count mod 4)
          pad_left_nxt = {1'b0, ~addr_cnt_r[1:0]};
          phase_nxt    = (addr_cnt_r[1:0] == 2'd3) ? SEC_TYPE : SEC_ADDR_PAD;
        end
      end
      SEC_ADDR_PAD: begin
        sec          = SEC_ADDR_PAD;
        pad_left_nxt = pad_left_r - 3'd1;
        if (pad_left_nxt == 3'd0) phase_nxt = SEC_TYPE;
      end
      SEC_TYPE: begin
        if ((type_cnt_r == '0) && (in_byte_r != COMMA_CHAR)) begin
          sec          = SEC_REJECT;
          phase_nxt    = SEC_REJECT;
          hdr_good_nxt = 1'b0;
        end else if (in_byte_r != 8'd0) begin
          sec          = SEC_TYPE;
          type_cnt_nxt = sat_inc(type_cnt_r);
        end else begin
          sec             = SEC_TYPE_PAD;
          type_closed_nxt = 1'b1;
          pad_left_nxt    = {1'b0, ~type_cnt_r[1:0]};
          phase_nxt       = (type_cnt_r[1:0] == 2'd3) ? SEC_DATA : SEC_TYPE_PAD;
        end
      end
      SEC_TYPE_PAD: begin
        sec          = SEC_TYPE_PAD;
        pad_left_nxt = pad_left_r - 3'd1;
        if (pad_left_nxt == 3'd0) phase_nxt = SEC_DATA;
      end
      SEC_DATA: begin
        sec = SEC_DATA;
      end
      default: begin
        sec = SEC_REJECT;
      end
    endcase
  end

  // header geometry: both fields rounded up to the next word, terminator included
  assign type_start = {1'b0, addr_cnt_nxt} + 16'd4 - {14'd0, addr_cnt_nxt[1:0]};
  assign doff = type_closed_nxt
              ? ({1'b0, type_start} + {2'b00, type_cnt_nxt} + 17'd4
                 - {15'd0, type_cnt_nxt[1:0]})
              : 17'd0;
  assign valid_c  = hdr_good_nxt && (sec == SEC_DATA) && (doff < {2'b00, pos_nxt});
  assign doff_sat = (doff > {2'b00, CNT_MAX}) ? CNT_MAX : doff[CntW-1:0];
  assign dlen     = valid_c ? (pos_nxt - doff[CntW-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_byte_r <= in_message_byte;
      in_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= SEC_ADDR;
      pos_r         <= '0;
      addr_cnt_r    <= '0;
      type_cnt_r    <= '0;
      pad_left_r    <= '0;
      hdr_good_r    <= 1'b1;
      type_closed_r <= 1'b0;
    end else if (step) begin
      if (in_last_r) begin
        // ready for the next message
        phase_r       <= SEC_ADDR;
        pos_r         <= '0;
        addr_cnt_r    <= '0;
        type_cnt_r    <= '0;
        pad_left_r    <= '0;
        hdr_good_r    <= 1'b1;
        type_closed_r <= 1'b0;
      end else begin
        phase_r       <= phase_nxt;
        pos_r         <= pos_nxt;
        addr_cnt_r    <= addr_cnt_nxt;
        type_cnt_r    <= type_cnt_nxt;
        pad_left_r    <= pad_left_nxt;
        hdr_good_r    <= hdr_good_nxt;
        type_closed_r <= type_closed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
    if (step) begin
      byte_out_r  <= in_byte_r;
      section_r   <= sec;
      done_r      <= in_last_r;
      msg_valid_r <= in_last_r && valid_c;
      addr_len_r  <= in_last_r ? addr_cnt_nxt : '0;
      type_len_r  <= in_last_r ? type_cnt_nxt : '0;
      data_off_r  <= in_last_r ? doff_sat : '0;
      data_len_r  <= in_last_r ? dlen : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_out       = byte_out_r;
  assign out_section        = section_r;
  assign out_message_done   = done_r;
  assign out_message_valid  = msg_valid_r;
  assign out_address_length = addr_len_r;
  assign out_type_length    = type_len_r;
  assign out_data_offset    = data_off_r;
  assign out_data_length    = data_len_r;

  `OHD_ASSERT_NOW(a_geom_only_at_end,
    out_valid_r && !done_r,
    !msg_valid_r && addr_len_r == '0 && type_len_r == '0 && data_off_r == '0
      && data_len_r == '0,
    "geometry reported on a beat that does not end the message")

  `OHD_ASSERT_NOW(a_valid_means_data,
    out_valid_r && msg_valid_r,
    section_r == SEC_DATA && data_len_r != '0,
    "valid message without argument data")

  `OHD_ASSERT_NEXT(a_clear_after_last,
    step && in_last_r,
    phase_r == SEC_ADDR && pos_r == '0 && hdr_good_r && !type_closed_r,
    "header state not cleared after the last byte")

  `OHD_ASSERT_NOW(a_pad_only_in_pad,
    pad_left_r != 3'd0,
    phase_r == SEC_ADDR_PAD || phase_r == SEC_TYPE_PAD,
    "padding count left over outside a padding phase")

endmodule

// ===== verif/osc_message_header_deframer_checker.sv =====
// checker for the osc message header deframer: watches both beat channels,
// works out the tag and header geometry of every byte and compares results
// depends on osc_hdr_pkg
`timescale 1ns / 1ps

module osc_message_header_deframer_checker
  import osc_hdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_message_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte_out,
  input  logic [2:0] out_section,
  input  logic       out_message_done,
  input  logic       out_message_valid,
  input  cnt_t       out_address_length,
  input  cnt_t       out_type_length,
  input  cnt_t       out_data_offset,
  input  cnt_t       out_data_length,
  output int         fail_count,
  output int         pending,
  output int         beats_seen
);

  typedef struct {
    logic [7:0] byte_val;
    logic [2:0] section;
    logic       done;
    logic       good;
    cnt_t       addr_len;
    cnt_t       type_len;
    cnt_t       data_off;
    cnt_t       data_len;
  } byte_tag_t;

  byte_tag_t  tag_q[$];
  int         errs = 0;
  int         seen = 0;

  // header walk state
  logic [2:0] walk_phase;
  cnt_t       pos_cnt;
  cnt_t       addr_cnt;
  cnt_t       type_cnt;
  logic [2:0] pad_cnt;
  logic       hdr_ok;
  logic       type_done;

  function automatic void clear_walk();
    walk_phase = SEC_ADDR;
    pos_cnt = '0;
    addr_cnt = '0;
    type_cnt = '0;
    pad_cnt = '0;
    hdr_ok = 1'b1;
    type_done = 1'b0;
  endfunction

  function automatic byte_tag_t tag_byte(input logic [7:0] b, input logic last);
    byte_tag_t e;
    logic first;
    int length;
    int tstart;
    int doff;
    logic ok;
    first = (pos_cnt == '0);
    if (pos_cnt == CNT_MAX) hdr_ok = 1'b0;
    if (pos_cnt != CNT_MAX) pos_cnt = pos_cnt + 1'b1;
    e = '{default: '0};
    e.byte_val = b;
    e.done = last;
    case (walk_phase)
      SEC_ADDR: begin
        if (first && b != SLASH_CHAR) begin
          e.section = SEC_REJECT;
          walk_phase = SEC_REJECT;
          hdr_ok = 1'b0;
        end else if (b != 8'h00) begin
          e.section = SEC_ADDR;
          if (addr_cnt != CNT_MAX) addr_cnt = addr_cnt + 1'b1;
        end else begin
          // the zero itself counts as address padding
          e.section = SEC_ADDR_PAD;
          pad_cnt = 3'd3 - {1'b0, addr_cnt[1:0]};
          walk_phase = (pad_cnt == 3'd0) ? SEC_TYPE : SEC_ADDR_PAD;
        end
      end
      SEC_ADDR_PAD: begin
        e.section = SEC_ADDR_PAD;
        pad_cnt = pad_cnt - 3'd1;
        if (pad_cnt == 3'd0) walk_phase = SEC_TYPE;
      end
      SEC_TYPE: begin
        if (type_cnt == '0 && b != COMMA_CHAR) begin
          e.section = SEC_REJECT;
          walk_phase = SEC_REJECT;
          hdr_ok = 1'b0;
        end else if (b != 8'h00) begin
          e.section = SEC_TYPE;
          if (type_cnt != CNT_MAX) type_cnt = type_cnt + 1'b1;
        end else begin
          e.section = SEC_TYPE_PAD;
          type_done = 1'b1;
          pad_cnt = 3'd3 - {1'b0, type_cnt[1:0]};
          walk_phase = (pad_cnt == 3'd0) ? SEC_DATA : SEC_TYPE_PAD;
        end
      end
      SEC_TYPE_PAD: begin
        e.section = SEC_TYPE_PAD;
        pad_cnt = pad_cnt - 3'd1;
        if (pad_cnt == 3'd0) walk_phase = SEC_DATA;
      end
      SEC_DATA: e.section = SEC_DATA;
      default:  e.section = SEC_REJECT;
    endcase
    if (last) begin
      length = int'(pos_cnt);
      tstart = addr_cnt + 4 - addr_cnt[1:0];
      // an unclosed type tag gives no data offset at all
      doff = type_done ? (tstart + type_cnt + 4 - type_cnt[1:0]) : 0;
      ok = hdr_ok && e.section == SEC_DATA && doff < length;
      e.good = ok;
      e.addr_len = addr_cnt;
      e.type_len = type_cnt;
      e.data_off = (doff > 32767) ? CNT_MAX : cnt_t'(doff);
      e.data_len = ok ? cnt_t'(length - doff) : '0;
      clear_walk();
    end
    return e;
  endfunction

  task automatic report(input string what);
    errs++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    byte_tag_t want;
    if (!rst_n) begin
      tag_q.delete();
      clear_walk();
    end else begin
      if (out_valid && !out_stall) begin
        if (tag_q.size() == 0) begin
          report("result beat with nothing outstanding");
        end else begin
          want = tag_q.pop_front();
          seen++;
          check_field("byte_out", 32'(out_byte_out), 32'(want.byte_val));
          check_field("section", 32'(out_section), 32'(want.section));
          check_field("message_done", 32'(out_message_done), 32'(want.done));
          check_field("message_valid", 32'(out_message_valid), 32'(want.good));
          check_field("address_length", 32'(out_address_length), 32'(want.addr_len));
          check_field("type_length", 32'(out_type_length), 32'(want.type_len));
          check_field("data_offset", 32'(out_data_offset), 32'(want.data_off));
          check_field("data_length", 32'(out_data_length), 32'(want.data_len));
        end
      end
      if (in_valid && !in_stall) tag_q.push_back(tag_byte(in_message_byte, in_last_byte));
    end
    fail_count <= errs;
    pending <= tag_q.size();
    beats_seen <= seen;
  end

endmodule

// ===== verif/tb_osc_message_header_deframer_top.sv =====
// testbench top for osc_message_header_deframer_top: builds osc messages,
// drives bytes with random idling and stalls, and gives the verdict
// depends on osc_hdr_pkg, the deframer rtl and osc_message_header_deframer_checker
`timescale 1ns / 1ps

module tb_osc_message_header_deframer_top;
  import osc_hdr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BYTES = 400;

  typedef enum int { MK_WELL, MK_NO_SLASH, MK_NO_COMMA, MK_CUT, MK_NOISE } msg_kind_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_message_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_out;
  logic [2:0] out_section;
  logic       out_message_done;
  logic       out_message_valid;
  cnt_t       out_address_length;
  cnt_t       out_type_length;
  cnt_t       out_data_offset;
  cnt_t       out_data_length;

  int fail_count;
  int pending;
  int beats_seen;

  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int msg_count = 0;
  int byte_count = 0;

  logic [7:0] msg_bytes[$];

  always #5 clk = ~clk;

  osc_message_header_deframer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_message_byte    (in_message_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_out       (out_byte_out),
    .out_section        (out_section),
    .out_message_done   (out_message_done),
    .out_message_valid  (out_message_valid),
    .out_address_length (out_address_length),
    .out_type_length    (out_type_length),
    .out_data_offset    (out_data_offset),
    .out_data_length    (out_data_length)
  );

  osc_message_header_deframer_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_message_byte    (in_message_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_out       (out_byte_out),
    .out_section        (out_section),
    .out_message_done   (out_message_done),
    .out_message_valid  (out_message_valid),
    .out_address_length (out_address_length),
    .out_type_length    (out_type_length),
    .out_data_offset    (out_data_offset),
    .out_data_length    (out_data_length),
    .fail_count         (fail_count),
    .pending            (pending),
    .beats_seen         (beats_seen)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_stall <= 1'b1;
      hold_left <= 120;
      hold_served <= hold_asked;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      in_message_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_message_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    byte_count++;
    @(negedge clk);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_count++;
  endtask

  function automatic logic [7:0] pad_byte();
    // padding is not checked, so sometimes it carries junk
    return ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
  endfunction

  task automatic build_message(input msg_kind_t kind, input int addr_n, input int type_n,
                               input int data_n);
    logic [7:0] b;
    msg_bytes.delete();
    if (kind == MK_NOISE) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    if (kind == MK_NO_SLASH) begin
      do b = 8'($urandom); while (b == SLASH_CHAR);
      msg_bytes.push_back(b);
    end else begin
      msg_bytes.push_back(SLASH_CHAR);
    end
    repeat (addr_n - 1) msg_bytes.push_back(8'($urandom_range(1, 255)));
    msg_bytes.push_back(8'h00);
    repeat (3 - (addr_n & 3)) msg_bytes.push_back(pad_byte());
    if (kind == MK_NO_COMMA) begin
      do b = 8'($urandom); while (b == COMMA_CHAR);
      msg_bytes.push_back(b);
    end else begin
      msg_bytes.push_back(COMMA_CHAR);
    end
    repeat (type_n - 1) msg_bytes.push_back(8'($urandom_range(1, 255)));
    msg_bytes.push_back(8'h00);
    repeat (3 - (type_n & 3)) msg_bytes.push_back(pad_byte());
    repeat (data_n) msg_bytes.push_back(8'($urandom));
    if (kind == MK_CUT) msg_bytes = msg_bytes[0:$urandom_range(0, msg_bytes.size() - 2)];
  endtask

  task automatic random_message();
    int pick;
    msg_kind_t kind;
    pick = $urandom_range(99);
    if (pick < 70) kind = MK_WELL;
    else if (pick < 78) kind = MK_NO_SLASH;
    else if (pick < 86) kind = MK_NO_COMMA;
    else if (pick < 96) kind = MK_CUT;
    else kind = MK_NOISE;
    build_message(kind, $urandom_range(1, 9), $urandom_range(1, 7),
                  ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12));
    send_message();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int start_bytes;
    bit held;
    bit paused;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: missing slash with extreme bytes, nonzero padding,
    // missing comma and a header cut short
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);
    msg_bytes = '{SLASH_CHAR, 8'h00, 8'hFF, 8'h80, COMMA_CHAR, 8'h69, 8'h00, 8'h5A,
                  8'hFF, 8'h00};
    send_message();
    msg_bytes = '{SLASH_CHAR, 8'h00, 8'h00, 8'h00, 8'h69};
    send_message();
    send_beat(SLASH_CHAR, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 13 : (ph == 1) ? 63 : 0;
      rcv_idle <= (ph == 0) ? 63 : (ph == 1) ? 13 : 0;
      start_bytes = byte_count;
      held = 1'b0;
      paused = 1'b0;
      while (byte_count - start_bytes < PHASE_BYTES) begin
        if (ph == 0 && !held && byte_count - start_bytes > PHASE_BYTES / 2) begin
          // receiver holds off while bytes keep coming, so the input backs up
          hold_asked <= hold_asked + 1;
          held = 1'b1;
        end
        if (ph == 1 && !paused && byte_count - start_bytes > PHASE_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        random_message();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);

    $display("sent %0d messages (%0d bytes): well-formed, rejected, truncated and noise",
             msg_count, byte_count);
    $display("%0d result beats compared under three idling patterns and a long hold-off",
             beats_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
